>>> rtl/transmit_queue_with_bypass_top_defines.svh
// ----------------------------------------------------------------------------
// Transmit queue assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TRANSMIT_QUEUE_WITH_BYPASS_TOP_DEFINES_SVH
`define TRANSMIT_QUEUE_WITH_BYPASS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check a property on every clk_i edge outside reset
`define TQB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tqb assertion failed");
// check that a condition never holds outside reset
`define TQB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("tqb forbidden condition seen");
`else
`define TQB_ASSERT(lbl, prop)
`define TQB_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> rtl/tqb_pkg.sv
// ----------------------------------------------------------------------------
// Transmit queue package
// Depth, widths and beat types shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqb_pkg;

  // queue depth and the count width that can hold it
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // item kinds
  localparam logic KindPut  = 1'b0;
  localparam logic KindDone = 1'b1;

  // input beat
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } tqb_in_t;

  // result beat
  typedef struct packed {
    logic       rejected;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       queue_empty;
  } tqb_out_t;

  // per-cell control
  typedef struct packed {
    logic shift;  // take the byte from the upper neighbor
    logic load;   // take the incoming byte
  } tqb_cell_ctrl_t;

endpackage

>>> rtl/transmit_queue_with_bypass_top.sv
// ----------------------------------------------------------------------------
// Transmit queue with idle-line bypass
// Byte queue in front of a serial transmitter: a put goes straight out when
// the line is idle, otherwise it is queued or rejected when full; a done beat
// pops the oldest byte to the line or marks the line idle.
//
//   channel  | ports                   | handshake
//   ---------+-------------------------+----------------------------------
//   item     | start_i, busy_o, in_i   | taken when start_i && !busy_o
//   result   | done_o, res_o           | one-cycle strobe, always taken
//
// An item's result is on res_o with done_o in the cycle after it is taken. The
// count, line state and cell chain all update in that same cycle, so busy_o
// stays low and an item may follow every cycle.
// Reset clears the count and line state; the cell bytes need no reset.
// The receiver cannot stall, so results never back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "transmit_queue_with_bypass_top_defines.svh"

module transmit_queue_with_bypass_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  tqb_pkg::tqb_in_t  in_i,
  output logic              done_o,
  output tqb_pkg::tqb_out_t res_o
);
  import tqb_pkg::*;

  logic            accept;
  logic            line_busy_q, line_busy_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  logic [7:0]      head;
  logic            done_q;
  tqb_out_t        res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // decide bypass, queue, reject or pop for the accepted beat
  always_comb begin
    line_busy_d = line_busy_q;
    count_d     = count_q;
    push        = 1'b0;
    pop         = 1'b0;
    res_d       = '0;
    if (accept) begin
      if (in_i.kind == KindPut) begin
        if (!line_busy_q) begin
          res_d.send_valid = 1'b1;
          res_d.send_byte  = in_i.data_byte;
          line_busy_d      = 1'b1;
        end else if (count_q == CntW'(QueueDepth)) begin
          res_d.rejected = 1'b1;
        end else begin
          push    = 1'b1;
          count_d = count_q + CntW'(1);
        end
      end else if (line_busy_q) begin
        if (count_q != '0) begin
          pop              = 1'b1;
          res_d.send_valid = 1'b1;
          res_d.send_byte  = head;
          count_d          = count_q - CntW'(1);
        end else begin
          line_busy_d = 1'b0;
        end
      end
    end
    res_d.queue_empty = (count_d == '0);
  end

  // hold the queue bytes
  tqb_chain u_chain (
    .clk_i   (clk_i),
    .push_i  (push),
    .pop_i   (pop),
    .count_i (count_q),
    .byte_i  (in_i.data_byte),
    .head_o  (head)
  );

  // advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_busy_q <= 1'b0;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      line_busy_q <= line_busy_d;
      count_q     <= count_d;
      done_q      <= accept;
    end
  end

  // hold the result beat
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `TQB_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth))
  `TQB_ASSERT(a_queue_needs_busy, (count_q != '0) |-> line_busy_q)
  `TQB_ASSERT(a_strobe_follows_beat, accept |=> done_q)
  `TQB_ASSERT_NEVER(a_send_and_reject, done_q && res_q.send_valid && res_q.rejected)
  `TQB_ASSERT(a_idle_byte_zero, (done_q && !res_q.send_valid) |-> (res_q.send_byte == 8'h00))

endmodule

>>> rtl/tqb_cell.sv
// ----------------------------------------------------------------------------
// Transmit queue cell
// One byte slot; shifts toward the head on a pop or loads a new byte on a put.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqb_cell (
  input  logic                    clk_i,
  input  tqb_pkg::tqb_cell_ctrl_t ctrl_i,
  input  logic [7:0]              upper_i,
  input  logic [7:0]              byte_i,
  output logic [7:0]              data_o
);
  import tqb_pkg::*;

  logic [7:0] data_q;
  logic [7:0] data_d;

  // select shift, load or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = upper_i;
    end else if (ctrl_i.load) begin
      data_d = byte_i;
    end
  end

  // hold the slot byte
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> rtl/tqb_chain.sv
// ----------------------------------------------------------------------------
// Transmit queue cell chain
// Row of byte cells; cell 0 holds the oldest byte, a put fills the first free
// cell and a pop moves every byte one cell toward the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqb_chain (
  input  logic                     clk_i,
  input  logic                     push_i,
  input  logic                     pop_i,
  input  logic [tqb_pkg::CntW-1:0] count_i,
  input  logic [7:0]               byte_i,
  output logic [7:0]               head_o
);
  import tqb_pkg::*;

  logic [7:0] cell_data [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    tqb_cell_ctrl_t ctrl;
    logic [7:0]     upper;

    // load only the first free cell, shift all on a pop
    assign ctrl.shift = pop_i;
    assign ctrl.load  = push_i && (count_i == CntW'(i));

    // last cell takes a blank byte from above
    if (i == QueueDepth - 1) begin : g_top
      assign upper = 8'h00;
    end else begin : g_mid
      assign upper = cell_data[i + 1];
    end

    tqb_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .upper_i (upper),
      .byte_i  (byte_i),
      .data_o  (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule
